FILE: design/ckdht_pkg.sv
// ----------------------------------------------------------------------------
// Coordinate-keyed hash table package
// Shared constants, status codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ckdht_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int SLOT_W      = $clog2(TABLE_DEPTH);
	localparam int OCC_W       = $clog2(TABLE_DEPTH + 1);
	localparam int VALUE_W     = 32;
	localparam int STATUS_W    = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_FOUND     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4,
		ST_COLLISION = 3'd5
	} ckdht_status_t;

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_LOOK   = 4'b0100,
		S_DECIDE = 4'b1000
	} ckdht_state_t;

	typedef struct packed {
		logic clear_en;
		logic load_in;
		logic look;
		logic commit;
	} ckdht_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic out_free;
	} ckdht_sts_t;

endpackage

FILE: design/coord_keyed_direct_hash_table_core.sv
// ----------------------------------------------------------------------------
// Coordinate-keyed direct-mapped hash table
// Insert, update and search of 32-bit values keyed by an (x, y) coordinate,
// indexed by the Cantor pairing of the key modulo the table depth.
//
//   Channel  Handshake          Payload
//   input    in_valid/in_stall  kind, key_x, key_y, value_in
//   output   out_valid/out_stall status, value_out, slot
//
// After reset the block runs a clearing pass over all 512 slots of the memory
// and holds in_stall high until it ends.
// Each request passes three steps: accept, memory lookup, then decide and
// write back; the registered read of the slot memory and its write-back set
// this order. A new request is accepted only after the last has decided.
// A result waits in the output register under out_stall; the next request
// is still accepted and its decide step holds until the register frees.
// ----------------------------------------------------------------------------
module coord_keyed_direct_hash_table_core import ckdht_pkg::*; #(
	parameter int COORD_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      kind,
	input  logic [COORD_BITS-1:0]     key_x,
	input  logic [COORD_BITS-1:0]     key_y,
	input  logic signed [VALUE_W-1:0] value_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [STATUS_W-1:0]       status,
	output logic signed [VALUE_W-1:0] value_out,
	output logic [SLOT_W-1:0]         slot
);

	ckdht_cmd_t cmd;
	ckdht_sts_t sts;

	ckdht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	ckdht_dpath #(
		.COORD_BITS (COORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.kind      (kind),
		.key_x     (key_x),
		.key_y     (key_y),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.value_out (value_out),
		.slot      (slot)
	);

endmodule

FILE: design/ckdht_ctrl.sv
// ----------------------------------------------------------------------------
// Coordinate-keyed hash table controller
// Sequences the clearing pass after reset and the accept, lookup and
// decide steps of each request.
// ----------------------------------------------------------------------------
module ckdht_ctrl import ckdht_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  ckdht_sts_t sts,
	output ckdht_cmd_t cmd
);

	ckdht_state_t state_q;
	ckdht_state_t state_next;

	always_comb begin
		state_next   = state_q;
		cmd          = '0;
		in_stall     = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (sts.clear_done) begin
					state_next = S_IDLE;
				end
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_next  = S_LOOK;
				end
			end
			S_LOOK: begin
				cmd.look   = 1'b1;
				state_next = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

FILE: design/ckdht_dpath.sv
// ----------------------------------------------------------------------------
// Coordinate-keyed hash table datapath
// Request registers, Cantor pairing hash, slot memory with registered read,
// occupancy counter, clear sweep counter and the result register.
// ----------------------------------------------------------------------------
module ckdht_dpath import ckdht_pkg::*; #(
	parameter int COORD_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ckdht_cmd_t                cmd,
	output ckdht_sts_t                sts,
	input  logic                      kind,
	input  logic [COORD_BITS-1:0]     key_x,
	input  logic [COORD_BITS-1:0]     key_y,
	input  logic signed [VALUE_W-1:0] value_in,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [STATUS_W-1:0]       status,
	output logic signed [VALUE_W-1:0] value_out,
	output logic [SLOT_W-1:0]         slot
);

	localparam int KEY_W   = 2 * COORD_BITS;
	localparam int SUM_W   = COORD_BITS + 1;
	localparam int HASH_W  = 2 * SUM_W + SLOT_W;
	localparam int ENTRY_W = 1 + KEY_W + VALUE_W;

	logic                 kind_q;
	logic [KEY_W-1:0]     key_q;
	logic [VALUE_W-1:0]   val_q;
	logic [SLOT_W-1:0]    idx_q;
	logic [ENTRY_W-1:0]   rd_q;
	logic [SLOT_W-1:0]    clr_cnt_q;
	logic [OCC_W-1:0]     occ_q;

	logic                 out_valid_q;
	ckdht_status_t        status_q;
	logic [VALUE_W-1:0]   value_q;
	logic [SLOT_W-1:0]    slot_q;

	logic [ENTRY_W-1:0]   mem [TABLE_DEPTH];

	logic [SUM_W-1:0]     sum;
	logic [HASH_W-1:0]    prod;
	logic [HASH_W-1:0]    hash;
	logic [SLOT_W-1:0]    hash_idx;

	logic                 held;
	logic                 same;
	logic                 full;
	logic                 wr_hit;
	logic                 occ_inc;
	ckdht_status_t        dec_status;
	logic [VALUE_W-1:0]   dec_value;

	logic                 mem_we;
	logic [SLOT_W-1:0]    mem_waddr;
	logic [ENTRY_W-1:0]   mem_wdata;

	// Cantor pairing; only the low slot bits of the pairing are kept.
	always_comb begin
		sum      = SUM_W'(key_q[COORD_BITS-1:0]) + SUM_W'(key_q[KEY_W-1:COORD_BITS]);
		prod     = HASH_W'(sum) * (HASH_W'(sum) + HASH_W'(1));
		hash     = (prod >> 1) + HASH_W'(key_q[KEY_W-1:COORD_BITS]);
		hash_idx = hash[SLOT_W-1:0];
	end

	always_comb begin
		held       = rd_q[ENTRY_W-1];
		same       = held && (rd_q[ENTRY_W-2 -: KEY_W] == key_q);
		full       = occ_q >= OCC_W'(TABLE_DEPTH);
		wr_hit     = 1'b0;
		occ_inc    = 1'b0;
		dec_value  = '0;
		priority if (kind_q) begin
			if (same) begin
				dec_status = ST_FOUND;
				dec_value  = rd_q[VALUE_W-1:0];
			end else begin
				dec_status = ST_NOT_FOUND;
			end
		end else if (!held) begin
			if (full) begin
				dec_status = ST_FULL;
			end else begin
				dec_status = ST_INSERTED;
				wr_hit     = 1'b1;
				occ_inc    = 1'b1;
			end
		end else if (same) begin
			dec_status = ST_UPDATED;
			wr_hit     = 1'b1;
		end else begin
			dec_status = ST_COLLISION;
		end
	end

	always_comb begin
		mem_we    = cmd.clear_en || (cmd.commit && wr_hit);
		mem_waddr = cmd.clear_en ? clr_cnt_q : idx_q;
		mem_wdata = cmd.clear_en ? '0 : {1'b1, key_q, val_q};
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.look) begin
			rd_q <= mem[hash_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			kind_q <= kind;
			key_q  <= {key_y, key_x};
			val_q  <= value_in;
		end
		if (cmd.look) begin
			idx_q <= hash_idx;
		end
		if (cmd.commit) begin
			status_q <= dec_status;
			value_q  <= dec_value;
			slot_q   <= idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_en) begin
				clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
			end
			if (cmd.commit && occ_inc) begin
				occ_q <= occ_q + OCC_W'(1);
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.clear_done = clr_cnt_q == SLOT_W'(TABLE_DEPTH - 1);
	assign sts.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign value_out = $signed(value_q);
	assign slot      = slot_q;

	// The occupancy count never passes the table depth.
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(TABLE_DEPTH))
		else $error("occupancy above table depth");

	// The occupancy count moves only on a committed insert.
	a_occ_commit: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q != $past(occ_q)) |-> $past(cmd.commit && occ_inc))
		else $error("occupancy changed without an insert");

	// Only a found result carries a nonzero value.
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_FOUND) |-> value_q == '0)
		else $error("nonzero value on a result that is not found");

	// A pending result is never overwritten.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("result register overrun");

endmodule

FILE: tb/tb_coord_keyed_direct_hash_table_core.sv
// ----------------------------------------------------------------------------
// Testbench for the coordinate-keyed direct-mapped hash table
// A directed table of requests (empty search, insert, update, found, collision
// on the shared slot of the two extreme keys) is followed by random sequences
// that mostly reuse inserted keys. Every result is checked against a local model
// of the slot table or, for the typed directed requests, against the expected
// values they carry. The input side sends in bursts, the output side stalls on
// changing patterns and once holds off long enough to back up the block.
// ----------------------------------------------------------------------------
module tb_coord_keyed_direct_hash_table_core;
	import ckdht_pkg::*;

	localparam int COORD_BITS   = 8;
	localparam int RANDOM_COUNT = 1700;
	localparam int HOLD_CYCLES  = 250;
	localparam int HOLD_AFTER   = 400;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int REPORT_MAX   = 10;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_LIGHT,
		RX_HEAVY,
		RX_TOGGLE
	} rx_mode_t;

	typedef struct {
		logic                      kind;
		logic [COORD_BITS-1:0]     x;
		logic [COORD_BITS-1:0]     y;
		logic signed [VALUE_W-1:0] value;
		bit                        typed;
		ckdht_status_t             status;
		logic signed [VALUE_W-1:0] value_out;
		logic [SLOT_W-1:0]         slot;
	} request_t;

	typedef struct {
		ckdht_status_t             status;
		logic signed [VALUE_W-1:0] value_out;
		logic [SLOT_W-1:0]         slot;
	} lookup_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic                      kind = OP_INSERT;
	logic [COORD_BITS-1:0]     key_x = '0;
	logic [COORD_BITS-1:0]     key_y = '0;
	logic signed [VALUE_W-1:0] value_in = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [STATUS_W-1:0]       status;
	logic signed [VALUE_W-1:0] value_out;
	logic [SLOT_W-1:0]         slot;

	coord_keyed_direct_hash_table_core #(
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.key_x     (key_x),
		.key_y     (key_y),
		.value_in  (value_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.value_out (value_out),
		.slot      (slot)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	request_t       requests[$];
	lookup_result_t pending_results[$];
	logic [15:0]    key_pool[$];

	bit                      model_valid[TABLE_DEPTH];
	logic [2*COORD_BITS-1:0] model_key[TABLE_DEPTH];
	logic [VALUE_W-1:0]      model_value[TABLE_DEPTH];
	int unsigned             model_occupancy = 0;

	int next_idx = 0;
	int acc_idx = 0;
	int burst_left = 0;
	int gap_left = 0;
	int results_seen = 0;
	int mismatches = 0;
	int status_seen[6];

	int       hold_left = 0;
	bit       hold_done = 1'b0;
	rx_mode_t rx_mode = RX_OPEN;
	int       mode_left = 0;
	int       cycle_count = 0;

	function automatic logic [SLOT_W-1:0] cantor_slot(logic [COORD_BITS-1:0] x,
			logic [COORD_BITS-1:0] y);
		int unsigned s;
		int unsigned n;
		s = x + y;
		n = (s * (s + 1)) / 2 + y;
		return SLOT_W'(n % TABLE_DEPTH);
	endfunction

	function automatic lookup_result_t apply_request(request_t rq);
		lookup_result_t          r;
		logic [2*COORD_BITS-1:0] key;
		bit                      held;
		bit                      same;
		key         = {rq.y, rq.x};
		r.slot      = cantor_slot(rq.x, rq.y);
		r.value_out = '0;
		held        = model_valid[r.slot];
		same        = held && (model_key[r.slot] == key);
		if (rq.kind == OP_SEARCH) begin
			if (same) begin
				r.status    = ST_FOUND;
				r.value_out = model_value[r.slot];
			end else begin
				r.status = ST_NOT_FOUND;
			end
		end else if (!held) begin
			if (model_occupancy >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				model_valid[r.slot] = 1'b1;
				model_key[r.slot]   = key;
				model_value[r.slot] = rq.value;
				model_occupancy++;
				r.status = ST_INSERTED;
			end
		end else if (same) begin
			model_value[r.slot] = rq.value;
			r.status            = ST_UPDATED;
		end else begin
			r.status = ST_COLLISION;
		end
		if (rq.typed) begin
			r.status    = rq.status;
			r.value_out = rq.value_out;
			r.slot      = rq.slot;
		end
		return r;
	endfunction

	task automatic add_request(logic k, logic [7:0] x, logic [7:0] y, logic [31:0] v,
			bit typed = 1'b0, ckdht_status_t st = ST_INSERTED, logic [31:0] vo = '0,
			logic [SLOT_W-1:0] sl = '0);
		request_t rq;
		rq.kind      = k;
		rq.x         = x;
		rq.y         = y;
		rq.value     = v;
		rq.typed     = typed;
		rq.status    = st;
		rq.value_out = vo;
		rq.slot      = sl;
		requests.push_back(rq);
	endtask

	task automatic build_requests();
		int          r;
		logic [15:0] key;
		add_request(OP_SEARCH, 8'd0, 8'd0, 32'hFFFF_FFFF, 1, ST_NOT_FOUND, 32'h0, 9'd0);
		add_request(OP_INSERT, 8'd0, 8'd0, 32'h7FFF_FFFF, 1, ST_INSERTED, 32'h0, 9'd0);
		add_request(OP_SEARCH, 8'd0, 8'd0, 32'h0, 1, ST_FOUND, 32'h7FFF_FFFF, 9'd0);
		add_request(OP_INSERT, 8'd0, 8'd0, 32'h8000_0000, 1, ST_UPDATED, 32'h0, 9'd0);
		add_request(OP_SEARCH, 8'd0, 8'd0, 32'h0, 1, ST_FOUND, 32'h8000_0000, 9'd0);
		add_request(OP_INSERT, 8'd255, 8'd255, 32'hFFFF_FFFF, 1, ST_COLLISION, 32'h0, 9'd0);
		add_request(OP_SEARCH, 8'd255, 8'd255, 32'h0, 1, ST_NOT_FOUND, 32'h0, 9'd0);
		add_request(OP_INSERT, 8'd255, 8'd0, 32'hFFFF_FFFF);
		add_request(OP_SEARCH, 8'd255, 8'd0, 32'h0);
		add_request(OP_INSERT, 8'd0, 8'd255, 32'h0);
		add_request(OP_SEARCH, 8'd0, 8'd255, 32'hAAAA_AAAA);
		add_request(OP_INSERT, 8'd0, 8'd255, 32'h5555_5555);
		add_request(OP_SEARCH, 8'd0, 8'd255, 32'h0);
		add_request(OP_SEARCH, 8'd1, 8'd0, 32'h0);
		add_request(OP_INSERT, 8'd1, 8'd0, 32'h1);
		add_request(OP_INSERT, 8'd0, 8'd1, 32'hFFFF_FFFE);
		add_request(OP_SEARCH, 8'd1, 8'd0, 32'h0);
		add_request(OP_SEARCH, 8'd128, 8'd127, 32'h0);
		add_request(OP_INSERT, 8'd128, 8'd127, 32'h1234_5678);
		add_request(OP_SEARCH, 8'd128, 8'd127, 32'h0);
		add_request(OP_SEARCH, 8'd127, 8'd128, 32'h0);
		add_request(OP_SEARCH, 8'd255, 8'd255, 32'h0);
		key_pool = '{16'h0000, 16'h00FF, 16'hFF00, 16'h0001, 16'h0100, 16'h7F80};
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35 || r >= 90) begin
				key = 16'($urandom);
				if (r < 35) begin
					key_pool.push_back(key);
				end
			end else begin
				key = key_pool[$urandom_range(0, key_pool.size() - 1)];
			end
			add_request((r < 55) ? OP_INSERT : OP_SEARCH, key[7:0], key[15:8], $urandom);
		end
	endtask

	always @(posedge clk) begin
		lookup_result_t exp_r;
		if (!arst_n) begin
			in_valid   <= 1'b0;
			next_idx   <= 0;
			acc_idx    <= 0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				pending_results.push_back(apply_request(requests[acc_idx]));
				acc_idx <= acc_idx + 1;
			end
			if (!in_valid || !in_stall) begin
				if (next_idx < requests.size() && gap_left == 0) begin
					kind     <= requests[next_idx].kind;
					key_x    <= requests[next_idx].x;
					key_y    <= requests[next_idx].y;
					value_in <= requests[next_idx].value;
					in_valid <= 1'b1;
					next_idx <= next_idx + 1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 60);
						gap_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
						                                         : $urandom_range(0, 4);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
					if (gap_left > 0) begin
						gap_left <= gap_left - 1;
					end
				end
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (status < 6) begin
					status_seen[status]++;
				end
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("unexpected result transfer: status %0d value %0d slot %0d",
							status, value_out, slot);
					end
				end else begin
					exp_r = pending_results.pop_front();
					if (status !== exp_r.status || value_out !== exp_r.value_out
							|| slot !== exp_r.slot) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("result %0d mismatch: expected status %0d value %0d slot %0d, got status %0d value %0d slot %0d",
								results_seen, exp_r.status, exp_r.value_out, exp_r.slot,
								status, value_out, slot);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
			rx_mode   <= RX_OPEN;
			mode_left <= 0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && acc_idx >= HOLD_AFTER) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode   <= rx_mode_t'($urandom_range(0, 3));
				mode_left <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (rx_mode)
				RX_OPEN: begin
					out_stall <= 1'b0;
				end
				RX_LIGHT: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				RX_HEAVY: begin
					out_stall <= ($urandom_range(0, 3) != 0);
				end
				default: begin
					out_stall <= ~out_stall;
				end
			endcase
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles with %0d results outstanding", cycle_count,
			pending_results.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		build_requests();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		do begin
			@(posedge clk);
		end while (acc_idx < requests.size() || pending_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d requests and %0d results; occupancy reached %0d of %0d slots.",
			requests.size(), results_seen, model_occupancy, TABLE_DEPTH);
		$display("Statuses: inserted %0d, updated %0d, found %0d, not found %0d, collision %0d.",
			status_seen[ST_INSERTED], status_seen[ST_UPDATED], status_seen[ST_FOUND],
			status_seen[ST_NOT_FOUND], status_seen[ST_COLLISION]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d failed checks", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
